FILE: rtl/assert_macros.svh
// Assertion macros used by the RTL top level of the probe hash table.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define ASSERT_IMPLIES(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);
`define ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);
`else
`define ASSERT_IMPLIES(label, clk, rst, ante, cons, msg)
`define ASSERT_NEXT(label, clk, rst, ante, cons, msg)
`endif
`endif

FILE: rtl/pph_pkg.sv
// Shared codes, widths and controller/datapath interface types.
package pph_pkg;

   localparam int KEY_W          = 64;
   localparam int ENTRY_NUMBER_W = 10;
   localparam int STATUS_W       = 3;
   localparam int MODE_W         = 2;
   localparam int MIN_SIZE_LOG2  = 3;

   localparam logic [MODE_W-1:0] MODE_LOOKUP = 2'd0;
   localparam logic [MODE_W-1:0] MODE_INSERT = 2'd1;
   localparam logic [MODE_W-1:0] MODE_CLEAR  = 2'd2;

   localparam logic [STATUS_W-1:0] STATUS_FOUND     = 3'd0;
   localparam logic [STATUS_W-1:0] STATUS_NOT_FOUND = 3'd1;
   localparam logic [STATUS_W-1:0] STATUS_INSERTED  = 3'd2;
   localparam logic [STATUS_W-1:0] STATUS_UPDATED   = 3'd3;
   localparam logic [STATUS_W-1:0] STATUS_FULL      = 3'd4;
   localparam logic [STATUS_W-1:0] STATUS_CLEARED   = 3'd5;

   typedef struct packed {
      logic                accept;      // latch the request fields
      logic                load_in;     // start a probe from the request port hash
      logic                load_req;    // start a probe from the latched hash
      logic                load_ent;    // start a probe from the entry hash read
      logic                step;        // advance the probe sequence
      logic                sweep_min;   // begin clearing an 8-slot table
      logic                sweep_grow;  // begin clearing the grown table
      logic                sweep;       // clear one slot
      logic                clear_count;
      logic                rb_clear;
      logic                rb_read;     // read entry hash at the rebuild index
      logic                rb_place;    // place rebuild entry in the current slot
      logic                append;
      logic                update;
      logic                respond;
      logic [STATUS_W-1:0] status;
   } cmd_type;

   typedef struct packed {
      logic slot_empty;
      logic key_match;
      logic sweep_last;
      logic rb_done;
      logic store_full;
      logic at_limit;
      logic grow_over;
   } stat_type;

endpackage

FILE: rtl/perturbed_probe_hash_table.sv
// Insertion-ordered hash map with perturbed open-addressing probes (top level).
//
//   Channel   Handshake            Payload
//   request   start / busy         req_mode, req_key, req_hash, req_value
//   result    rsp_strobe           rsp_status, rsp_found_value, rsp_entry_number
//
// A transfer in is taken when start is high and busy is low; the result follows as a
// one-cycle strobe. Each occupied slot visited takes the states slot read, entry read and
// compare (ST_SLOT_RD, ST_SLOT_CHK, ST_ENT_CHK), set by the single slot port. Clear sweeps
// the eight slots of the smallest table. Growth clears 2^size slots one per cycle, then
// re-places every entry (ST_RB_HASH, ST_RB_INIT, then ST_RB_SLOT_RD and ST_RB_SLOT_CHK per
// slot visited), then probes again for the insert.
// After reset busy stays high while the first eight slots are cleared.
// The receiver cannot stall; results are never held.
`include "assert_macros.svh"
module perturbed_probe_hash_table #(
   parameter int MAX_SIZE_LOG2 = 10,
   parameter int MAX_ENTRIES   = 682,
   parameter int PROBE_SHIFT   = 5
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 start,
   output logic                                 busy,
   input  logic [pph_pkg::MODE_W-1:0]           req_mode,
   input  logic [pph_pkg::KEY_W-1:0]            req_key,
   input  logic [pph_pkg::KEY_W-1:0]            req_hash,
   input  logic [pph_pkg::KEY_W-1:0]            req_value,
   output logic                                 rsp_strobe,
   output logic [pph_pkg::STATUS_W-1:0]         rsp_status,
   output logic [pph_pkg::KEY_W-1:0]            rsp_found_value,
   output logic [pph_pkg::ENTRY_NUMBER_W-1:0]   rsp_entry_number
);

   pph_pkg::cmd_type  cmd;
   pph_pkg::stat_type stat;
   logic              rsp_no_entry;

   pph_ctrl u_ctrl (
      .clock    (clock),
      .reset    (reset),
      .start    (start),
      .req_mode (req_mode),
      .stat     (stat),
      .cmd      (cmd),
      .busy     (busy)
   );

   pph_dp #(
      .MAX_SIZE_LOG2 (MAX_SIZE_LOG2),
      .MAX_ENTRIES   (MAX_ENTRIES),
      .PROBE_SHIFT   (PROBE_SHIFT)
   ) u_dp (
      .clock            (clock),
      .reset            (reset),
      .req_key          (req_key),
      .req_hash         (req_hash),
      .req_value        (req_value),
      .cmd              (cmd),
      .stat             (stat),
      .rsp_strobe       (rsp_strobe),
      .rsp_status       (rsp_status),
      .rsp_found_value  (rsp_found_value),
      .rsp_entry_number (rsp_entry_number)
   );

   assign rsp_no_entry = (rsp_status == pph_pkg::STATUS_NOT_FOUND)
                         || (rsp_status == pph_pkg::STATUS_FULL)
                         || (rsp_status == pph_pkg::STATUS_CLEARED);

   `ASSERT_NEXT(a_accept_busy, clock, reset, start && !busy, busy, "accepted transfer did not raise busy")
   `ASSERT_NEXT(a_strobe_single, clock, reset, rsp_strobe, !rsp_strobe, "back-to-back result strobes")
   `ASSERT_IMPLIES(a_miss_zero, clock, reset, rsp_strobe && rsp_no_entry, rsp_found_value == '0 && rsp_entry_number == '0, "nonzero payload on a result without an entry")

endmodule

FILE: rtl/pph_ram.sv
// Generic single-port RAM with registered read data.
module pph_ram #(
   parameter int WIDTH = 64,
   parameter int DEPTH = 1024
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] addr,
   input  logic [WIDTH-1:0]         wdata,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[addr] <= wdata;
      end
      rdata_ff <= mem_ff[addr];
   end

   assign rdata = rdata_ff;

endmodule

FILE: rtl/pph_ctrl.sv
// Sequencing state machine for lookup, insert, clear and table growth.
module pph_ctrl (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         start,
   input  logic [pph_pkg::MODE_W-1:0]   req_mode,
   input  pph_pkg::stat_type            stat,
   output pph_pkg::cmd_type             cmd,
   output logic                         busy
);

   typedef enum logic [8:0] {
      ST_IDLE        = 9'b000000001,
      ST_SWEEP       = 9'b000000010,
      ST_SLOT_RD     = 9'b000000100,
      ST_SLOT_CHK    = 9'b000001000,
      ST_ENT_CHK     = 9'b000010000,
      ST_RB_HASH     = 9'b000100000,
      ST_RB_INIT     = 9'b001000000,
      ST_RB_SLOT_RD  = 9'b010000000,
      ST_RB_SLOT_CHK = 9'b100000000
   } state_type;

   state_type                    state_ff, state_in;
   logic [pph_pkg::MODE_W-1:0]   mode_ff, mode_in;
   logic                         rebuild_ff, rebuild_in;
   logic                         clear_pend_ff, clear_pend_in;
   logic                         is_insert;

   assign is_insert = (mode_ff == pph_pkg::MODE_INSERT);

   always_comb begin
      cmd           = '0;
      state_in      = state_ff;
      mode_in       = mode_ff;
      rebuild_in    = rebuild_ff;
      clear_pend_in = clear_pend_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (start) begin
               cmd.accept = 1'b1;
               mode_in    = req_mode;
               if (req_mode == pph_pkg::MODE_CLEAR) begin
                  cmd.sweep_min   = 1'b1;
                  cmd.clear_count = 1'b1;
                  clear_pend_in   = 1'b1;
                  rebuild_in      = 1'b0;
                  state_in        = ST_SWEEP;
               end else begin
                  cmd.load_in = 1'b1;
                  state_in    = ST_SLOT_RD;
               end
            end
         end
         ST_SWEEP: begin
            cmd.sweep = 1'b1;
            if (stat.sweep_last) begin
               if (rebuild_ff) begin
                  cmd.rb_clear = 1'b1;
                  state_in     = ST_RB_HASH;
               end else begin
                  if (clear_pend_ff) begin
                     cmd.respond = 1'b1;
                     cmd.status  = pph_pkg::STATUS_CLEARED;
                  end
                  clear_pend_in = 1'b0;
                  state_in      = ST_IDLE;
               end
            end
         end
         ST_SLOT_RD: begin
            state_in = ST_SLOT_CHK;
         end
         ST_SLOT_CHK: begin
            if (!stat.slot_empty) begin
               state_in = ST_ENT_CHK;
            end else if (!is_insert) begin
               cmd.respond = 1'b1;
               cmd.status  = pph_pkg::STATUS_NOT_FOUND;
               state_in    = ST_IDLE;
            end else if (stat.store_full || (stat.at_limit && stat.grow_over)) begin
               cmd.respond = 1'b1;
               cmd.status  = pph_pkg::STATUS_FULL;
               state_in    = ST_IDLE;
            end else if (stat.at_limit) begin
               cmd.sweep_grow = 1'b1;
               rebuild_in     = 1'b1;
               state_in       = ST_SWEEP;
            end else begin
               cmd.append  = 1'b1;
               cmd.respond = 1'b1;
               cmd.status  = pph_pkg::STATUS_INSERTED;
               state_in    = ST_IDLE;
            end
         end
         ST_ENT_CHK: begin
            if (stat.key_match) begin
               cmd.respond = 1'b1;
               if (is_insert) begin
                  cmd.update = 1'b1;
                  cmd.status = pph_pkg::STATUS_UPDATED;
               end else begin
                  cmd.status = pph_pkg::STATUS_FOUND;
               end
               state_in = ST_IDLE;
            end else begin
               cmd.step = 1'b1;
               state_in = ST_SLOT_RD;
            end
         end
         ST_RB_HASH: begin
            if (stat.rb_done) begin
               // All entries are placed; probe again for the pending insert.
               cmd.load_req = 1'b1;
               rebuild_in   = 1'b0;
               state_in     = ST_SLOT_RD;
            end else begin
               cmd.rb_read = 1'b1;
               state_in    = ST_RB_INIT;
            end
         end
         ST_RB_INIT: begin
            cmd.load_ent = 1'b1;
            state_in     = ST_RB_SLOT_RD;
         end
         ST_RB_SLOT_RD: begin
            state_in = ST_RB_SLOT_CHK;
         end
         ST_RB_SLOT_CHK: begin
            if (stat.slot_empty) begin
               cmd.rb_place = 1'b1;
               state_in     = ST_RB_HASH;
            end else begin
               cmd.step = 1'b1;
               state_in = ST_RB_SLOT_RD;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_SWEEP;
         mode_ff       <= pph_pkg::MODE_LOOKUP;
         rebuild_ff    <= 1'b0;
         clear_pend_ff <= 1'b0;
      end else begin
         state_ff      <= state_in;
         mode_ff       <= mode_in;
         rebuild_ff    <= rebuild_in;
         clear_pend_ff <= clear_pend_in;
      end
   end

   assign busy = (state_ff != ST_IDLE);

endmodule

FILE: rtl/pph_dp.sv
// Datapath: slot and entry memories, probe sequence, counters and result register.
module pph_dp #(
   parameter int MAX_SIZE_LOG2 = 10,
   parameter int MAX_ENTRIES   = 682,
   parameter int PROBE_SHIFT   = 5
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic [pph_pkg::KEY_W-1:0]            req_key,
   input  logic [pph_pkg::KEY_W-1:0]            req_hash,
   input  logic [pph_pkg::KEY_W-1:0]            req_value,
   input  pph_pkg::cmd_type                     cmd,
   output pph_pkg::stat_type                    stat,
   output logic                                 rsp_strobe,
   output logic [pph_pkg::STATUS_W-1:0]         rsp_status,
   output logic [pph_pkg::KEY_W-1:0]            rsp_found_value,
   output logic [pph_pkg::ENTRY_NUMBER_W-1:0]   rsp_entry_number
);

   localparam int KW    = pph_pkg::KEY_W;
   localparam int SLOTS = 1 << MAX_SIZE_LOG2;
   localparam int IW    = MAX_SIZE_LOG2;
   localparam int CW    = $clog2(MAX_ENTRIES + 1);
   localparam int EW    = $clog2(MAX_ENTRIES);
   localparam int SZW   = $clog2(MAX_SIZE_LOG2 + 1);
   localparam int MW    = CW + 2;
   localparam int LGW   = $clog2(MW + 1);
   localparam int LIMW  = MAX_SIZE_LOG2 + 1;
   localparam int CMPW  = (CW > LIMW) ? CW : LIMW;

   logic [KW-1:0]   key_ff, hash_ff, value_ff;
   logic [SZW-1:0]  size_ff, size_in;
   logic [CW-1:0]   count_ff, count_in;
   logic [CW-1:0]   rb_ix_ff, rb_ix_in;
   logic [IW-1:0]   sweep_ff, sweep_in;
   logic [IW-1:0]   slot_ix_ff, slot_ix_in;
   logic [KW-1:0]   perturb_ff, perturb_in;

   logic                  rsp_strobe_ff;
   logic [pph_pkg::STATUS_W-1:0]       rsp_status_ff;
   logic [KW-1:0]                      rsp_value_ff;
   logic [pph_pkg::ENTRY_NUMBER_W-1:0] rsp_entry_ff;

   logic [IW-1:0]   size_mask;
   logic [KW-1:0]   perturb_sh;
   logic [IW+2:0]   next_sum;
   logic [IW-1:0]   slot_next;

   logic            slot_we;
   logic [IW-1:0]   slot_addr;
   logic [CW-1:0]   slot_wdata, slot_rdata;
   logic [CW-1:0]   hit_ix;

   logic            ent_we, val_we;
   logic [EW-1:0]   ent_addr;
   logic [KW-1:0]   key_rdata, hash_rdata, val_rdata;

   logic [MW-1:0]   grow_word;
   logic [LGW-1:0]  grow_lg;
   logic [LIMW-1:0] lim_mask, lim_pat, limit;

   // Probe sequence: perturb shifts first, then i*5 + perturb + 1 under the mask.
   assign size_mask  = ~({IW{1'b1}} << size_ff);
   assign perturb_sh = perturb_ff >> PROBE_SHIFT;
   assign next_sum   = {slot_ix_ff, 2'b00} + (IW+3)'(slot_ix_ff)
                       + (IW+3)'(perturb_sh[IW-1:0]) + (IW+3)'(1);
   assign slot_next  = next_sum[IW-1:0] & size_mask;

   assign hit_ix = slot_rdata - CW'(1);

   // Slot memory.
   assign slot_we    = cmd.sweep | cmd.append | cmd.rb_place;
   assign slot_addr  = cmd.sweep ? sweep_ff : slot_ix_ff;
   always_comb begin
      priority if (cmd.sweep) begin
         slot_wdata = '0;
      end else if (cmd.append) begin
         slot_wdata = count_ff + CW'(1);
      end else begin
         slot_wdata = rb_ix_ff + CW'(1);
      end
   end

   pph_ram #(.WIDTH(CW), .DEPTH(SLOTS)) u_slot_ram (
      .clock (clock),
      .we    (slot_we),
      .addr  (slot_addr),
      .wdata (slot_wdata),
      .rdata (slot_rdata)
   );

   // Entry store.
   assign ent_we = cmd.append;
   assign val_we = cmd.append | cmd.update;
   always_comb begin
      priority if (cmd.append) begin
         ent_addr = count_ff[EW-1:0];
      end else if (cmd.rb_read) begin
         ent_addr = rb_ix_ff[EW-1:0];
      end else begin
         ent_addr = hit_ix[EW-1:0];
      end
   end

   pph_ram #(.WIDTH(KW), .DEPTH(MAX_ENTRIES)) u_key_ram (
      .clock (clock),
      .we    (ent_we),
      .addr  (ent_addr),
      .wdata (key_ff),
      .rdata (key_rdata)
   );

   pph_ram #(.WIDTH(KW), .DEPTH(MAX_ENTRIES)) u_hash_ram (
      .clock (clock),
      .we    (ent_we),
      .addr  (ent_addr),
      .wdata (hash_ff),
      .rdata (hash_rdata)
   );

   pph_ram #(.WIDTH(KW), .DEPTH(MAX_ENTRIES)) u_value_ram (
      .clock (clock),
      .we    (val_we),
      .addr  (ent_addr),
      .wdata (value_ff),
      .rdata (val_rdata)
   );

   // Grown size: bit length of (((count*3) | 8) - 1) | 7.
   assign grow_word = ((({count_ff, 1'b0} + MW'(count_ff)) | MW'(8)) - MW'(1)) | MW'(7);
   always_comb begin
      grow_lg = '0;
      for (int b = 0; b < MW; b++) begin
         if (grow_word[b]) begin
            grow_lg = LGW'(b + 1);
         end
      end
   end

   // Usable limit floor(2^(size+1)/3) is alternating ones below bit size+1.
   assign lim_mask = {LIMW{1'b1}} >> (LIMW - 1 - int'(size_ff));
   always_comb begin
      for (int b = 0; b < LIMW; b++) begin
         lim_pat[b] = (1'(b) == ~size_ff[0]);
      end
   end
   assign limit = lim_mask & lim_pat;

   assign stat.slot_empty = (slot_rdata == '0);
   assign stat.key_match  = (hash_rdata == hash_ff) && (key_rdata == key_ff);
   assign stat.sweep_last = (sweep_ff == size_mask);
   assign stat.rb_done    = (rb_ix_ff == count_ff);
   assign stat.store_full = (int'(count_ff) >= MAX_ENTRIES);
   assign stat.at_limit   = (CMPW'(count_ff) >= CMPW'(limit));
   assign stat.grow_over  = (int'(grow_lg) > MAX_SIZE_LOG2);

   always_comb begin
      size_in    = size_ff;
      sweep_in   = sweep_ff;
      count_in   = count_ff;
      rb_ix_in   = rb_ix_ff;
      slot_ix_in = slot_ix_ff;
      perturb_in = perturb_ff;
      if (cmd.sweep_min) begin
         size_in  = SZW'(pph_pkg::MIN_SIZE_LOG2);
         sweep_in = '0;
      end else if (cmd.sweep_grow) begin
         size_in  = SZW'(grow_lg);
         sweep_in = '0;
      end else if (cmd.sweep) begin
         sweep_in = sweep_ff + IW'(1);
      end
      if (cmd.clear_count) begin
         count_in = '0;
      end else if (cmd.append) begin
         count_in = count_ff + CW'(1);
      end
      if (cmd.rb_clear) begin
         rb_ix_in = '0;
      end else if (cmd.rb_place) begin
         rb_ix_in = rb_ix_ff + CW'(1);
      end
      priority if (cmd.load_in) begin
         slot_ix_in = req_hash[IW-1:0] & size_mask;
         perturb_in = req_hash;
      end else if (cmd.load_req) begin
         slot_ix_in = hash_ff[IW-1:0] & size_mask;
         perturb_in = hash_ff;
      end else if (cmd.load_ent) begin
         slot_ix_in = hash_rdata[IW-1:0] & size_mask;
         perturb_in = hash_rdata;
      end else if (cmd.step) begin
         slot_ix_in = slot_next;
         perturb_in = perturb_sh;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         size_ff       <= SZW'(pph_pkg::MIN_SIZE_LOG2);
         sweep_ff      <= '0;
         count_ff      <= '0;
         rb_ix_ff      <= '0;
         rsp_strobe_ff <= 1'b0;
      end else begin
         size_ff       <= size_in;
         sweep_ff      <= sweep_in;
         count_ff      <= count_in;
         rb_ix_ff      <= rb_ix_in;
         rsp_strobe_ff <= cmd.respond;
      end
   end

   always_ff @(posedge clock) begin
      slot_ix_ff <= slot_ix_in;
      perturb_ff <= perturb_in;
      if (cmd.accept) begin
         key_ff   <= req_key;
         hash_ff  <= req_hash;
         value_ff <= req_value;
      end
      if (cmd.respond) begin
         rsp_status_ff <= cmd.status;
         rsp_value_ff  <= '0;
         rsp_entry_ff  <= '0;
         if (cmd.status == pph_pkg::STATUS_FOUND || cmd.status == pph_pkg::STATUS_UPDATED) begin
            rsp_value_ff <= val_rdata;
            rsp_entry_ff <= pph_pkg::ENTRY_NUMBER_W'(hit_ix[EW-1:0]);
         end else if (cmd.status == pph_pkg::STATUS_INSERTED) begin
            rsp_entry_ff <= pph_pkg::ENTRY_NUMBER_W'(count_ff);
         end
      end
   end

   assign rsp_strobe       = rsp_strobe_ff;
   assign rsp_status       = rsp_status_ff;
   assign rsp_found_value  = rsp_value_ff;
   assign rsp_entry_number = rsp_entry_ff;

endmodule

FILE: dv/perturbed_probe_hash_table_tb.sv
// Self-checking testbench for the perturbed-probe hash table.
`timescale 1ns / 1ps
module perturbed_probe_hash_table_tb;

   localparam int SIZE_LOG2_MAX = 10;
   localparam int ENTRY_CAP     = 682;
   localparam int SLOT_CAP      = 1 << SIZE_LOG2_MAX;
   localparam int WATCH_LIMIT   = 1000000;
   localparam logic [pph_pkg::MODE_W-1:0] MODE_SPARE = 2'd3;

   typedef struct packed {
      logic [pph_pkg::STATUS_W-1:0]       status;
      logic [pph_pkg::KEY_W-1:0]          found_value;
      logic [pph_pkg::ENTRY_NUMBER_W-1:0] entry_number;
   } outcome_type;

   logic                               clock = 1'b0;
   logic                               reset = 1'b1;
   logic                               start = 1'b0;
   logic                               busy;
   logic [pph_pkg::MODE_W-1:0]         req_mode = '0;
   logic [pph_pkg::KEY_W-1:0]          req_key = '0;
   logic [pph_pkg::KEY_W-1:0]          req_hash = '0;
   logic [pph_pkg::KEY_W-1:0]          req_value = '0;
   logic                               rsp_strobe;
   logic [pph_pkg::STATUS_W-1:0]       rsp_status;
   logic [pph_pkg::KEY_W-1:0]          rsp_found_value;
   logic [pph_pkg::ENTRY_NUMBER_W-1:0] rsp_entry_number;

   // Shadow copy of the table.
   int                        slot_map [SLOT_CAP];
   logic [pph_pkg::KEY_W-1:0] shadow_keys [ENTRY_CAP];
   logic [pph_pkg::KEY_W-1:0] shadow_hashes [ENTRY_CAP];
   logic [pph_pkg::KEY_W-1:0] shadow_values [ENTRY_CAP];
   int                        live_entries;
   int                        table_log2;

   outcome_type pending_q[$];
   int          mismatches;
   int          idle_pct;
   int          quiet_cycles;
   logic        took_item;

   perturbed_probe_hash_table dut (
      .clock(clock), .reset(reset), .start(start), .busy(busy),
      .req_mode(req_mode), .req_key(req_key), .req_hash(req_hash),
      .req_value(req_value), .rsp_strobe(rsp_strobe), .rsp_status(rsp_status),
      .rsp_found_value(rsp_found_value), .rsp_entry_number(rsp_entry_number)
   );

   always #5 clock = ~clock;

   function automatic logic [pph_pkg::KEY_W-1:0] next_probe(
         logic [pph_pkg::KEY_W-1:0] i, ref logic [pph_pkg::KEY_W-1:0] perturb);
      logic [pph_pkg::KEY_W-1:0] mask;
      mask = (64'd1 << table_log2) - 64'd1;
      perturb = perturb >> 5;
      return (i * 64'd5 + perturb + 64'd1) & mask;
   endfunction

   function automatic int locate_entry(logic [pph_pkg::KEY_W-1:0] key,
                                       logic [pph_pkg::KEY_W-1:0] hash);
      logic [pph_pkg::KEY_W-1:0] perturb;
      logic [pph_pkg::KEY_W-1:0] i;
      int s;
      perturb = hash;
      i = hash & ((64'd1 << table_log2) - 64'd1);
      for (int n = 0; n < 2 * SLOT_CAP + 64; n++) begin
         s = slot_map[i[SIZE_LOG2_MAX-1:0]];
         if (s == 0) return -1;
         if (shadow_hashes[s-1] == hash && shadow_keys[s-1] == key) return s - 1;
         i = next_probe(i, perturb);
      end
      return -1;
   endfunction

   function automatic int free_slot(logic [pph_pkg::KEY_W-1:0] hash);
      logic [pph_pkg::KEY_W-1:0] perturb;
      logic [pph_pkg::KEY_W-1:0] i;
      perturb = hash;
      i = hash & ((64'd1 << table_log2) - 64'd1);
      for (int n = 0; n < 2 * SLOT_CAP + 64; n++) begin
         if (slot_map[i[SIZE_LOG2_MAX-1:0]] == 0) break;
         i = next_probe(i, perturb);
      end
      return int'(i[SIZE_LOG2_MAX-1:0]);
   endfunction

   function automatic void wipe_slots();
      foreach (slot_map[k]) slot_map[k] = 0;
   endfunction

   // Computes the outcome of one request and updates the shadow table.
   function automatic outcome_type apply_request(logic [pph_pkg::MODE_W-1:0] mode,
                                                 logic [pph_pkg::KEY_W-1:0] key,
                                                 logic [pph_pkg::KEY_W-1:0] hash,
                                                 logic [pph_pkg::KEY_W-1:0] value);
      outcome_type o;
      int ix;
      int lg;
      logic [pph_pkg::KEY_W-1:0] m;
      bit ok;
      o = '{status: pph_pkg::STATUS_NOT_FOUND, found_value: '0, entry_number: '0};
      if (mode == pph_pkg::MODE_CLEAR) begin
         wipe_slots();
         live_entries = 0;
         table_log2 = pph_pkg::MIN_SIZE_LOG2;
         o.status = pph_pkg::STATUS_CLEARED;
      end else if (mode == pph_pkg::MODE_INSERT) begin
         ix = locate_entry(key, hash);
         if (ix >= 0) begin
            o.found_value = shadow_values[ix];
            shadow_values[ix] = value;
            o.entry_number = pph_pkg::ENTRY_NUMBER_W'(ix);
            o.status = pph_pkg::STATUS_UPDATED;
         end else begin
            ok = 1'b1;
            if (live_entries >= ENTRY_CAP) begin
               ok = 1'b0;
            end else if (live_entries >= ((2 << table_log2) / 3)) begin
               m = (((64'(live_entries) * 64'd3) | 64'd8) - 64'd1) | 64'd7;
               lg = 0;
               while (m != 0) begin
                  lg++;
                  m = m >> 1;
               end
               if (lg > SIZE_LOG2_MAX) begin
                  ok = 1'b0;
               end else begin
                  table_log2 = lg;
                  wipe_slots();
                  for (int e = 0; e < live_entries; e++)
                     slot_map[free_slot(shadow_hashes[e])] = e + 1;
               end
            end
            if (ok) begin
               slot_map[free_slot(hash)] = live_entries + 1;
               shadow_keys[live_entries] = key;
               shadow_hashes[live_entries] = hash;
               shadow_values[live_entries] = value;
               o.entry_number = pph_pkg::ENTRY_NUMBER_W'(live_entries);
               live_entries++;
               o.status = pph_pkg::STATUS_INSERTED;
            end else begin
               o.status = pph_pkg::STATUS_FULL;
            end
         end
      end else begin
         ix = locate_entry(key, hash);
         if (ix >= 0) begin
            o.found_value = shadow_values[ix];
            o.entry_number = pph_pkg::ENTRY_NUMBER_W'(ix);
            o.status = pph_pkg::STATUS_FOUND;
         end
      end
      return o;
   endfunction

   task automatic send_request(logic [pph_pkg::MODE_W-1:0] mode,
                               logic [pph_pkg::KEY_W-1:0] key,
                               logic [pph_pkg::KEY_W-1:0] hash,
                               logic [pph_pkg::KEY_W-1:0] value);
      if ($urandom_range(0, 99) < idle_pct) begin
         start <= 1'b0;
         repeat ($urandom_range(1, 4)) @(posedge clock);
      end
      start     <= 1'b1;
      req_mode  <= mode;
      req_key   <= key;
      req_hash  <= hash;
      req_value <= value;
      do @(posedge clock); while (busy);
      pending_q.push_back(apply_request(mode, key, hash, value));
   endtask

   task automatic drain_results();
      start <= 1'b0;
      while (pending_q.size() != 0) @(posedge clock);
   endtask

   function automatic logic [pph_pkg::KEY_W-1:0] rand64();
      return {$urandom(), $urandom()};
   endfunction

   // Hashes are often narrow so that probe chains collide and run long.
   function automatic logic [pph_pkg::KEY_W-1:0] pick_hash();
      case ($urandom_range(0, 3))
         0: return 64'($urandom_range(0, 15));
         1: return live_entries > 0 ? shadow_hashes[$urandom_range(0, live_entries - 1)]
                                    : rand64();
         default: return rand64();
      endcase
   endfunction

   task automatic random_request();
      int r;
      int e;
      r = $urandom_range(0, 99);
      e = live_entries > 0 ? $urandom_range(0, live_entries - 1) : 0;
      if (r < 35 && live_entries > 0)
         send_request(pph_pkg::MODE_LOOKUP, shadow_keys[e], shadow_hashes[e], rand64());
      else if (r < 45)
         send_request(pph_pkg::MODE_LOOKUP, rand64(), pick_hash(), rand64());
      else if (r < 60 && live_entries > 0)
         send_request(pph_pkg::MODE_INSERT, shadow_keys[e], shadow_hashes[e], rand64());
      else if (r < 94)
         send_request(pph_pkg::MODE_INSERT, rand64(), pick_hash(), rand64());
      else if (r < 97)
         send_request(MODE_SPARE, live_entries > 0 ? shadow_keys[e] : rand64(),
                      live_entries > 0 ? shadow_hashes[e] : rand64(), rand64());
      else
         send_request(pph_pkg::MODE_CLEAR, rand64(), rand64(), rand64());
   endtask

   task automatic test_directed();
      send_request(pph_pkg::MODE_LOOKUP, 64'd0, 64'd0, 64'd0);
      send_request(MODE_SPARE, '1, '1, '1);
      send_request(pph_pkg::MODE_INSERT, 64'd0, 64'd0, '1);
      send_request(pph_pkg::MODE_INSERT, '1, '1, 64'd0);
      send_request(pph_pkg::MODE_LOOKUP, 64'd0, 64'd0, 64'd0);
      send_request(MODE_SPARE, '1, '1, 64'd0);
      send_request(pph_pkg::MODE_INSERT, 64'd0, 64'd0, 64'h1234_5678_9abc_def0);
      // Same hash with a different key, and same key with a different hash.
      send_request(pph_pkg::MODE_INSERT, 64'd7, 64'd0, 64'd1);
      send_request(pph_pkg::MODE_INSERT, 64'd0, 64'd8, 64'd2);
      send_request(pph_pkg::MODE_LOOKUP, 64'd7, 64'd0, 64'd0);
      send_request(pph_pkg::MODE_LOOKUP, 64'd7, 64'd1, 64'd0);
      // The sixth entry forces the first growth of the table.
      send_request(pph_pkg::MODE_INSERT, 64'd9, 64'd16, 64'd3);
      send_request(pph_pkg::MODE_INSERT, 64'd10, 64'd24, 64'd4);
      send_request(pph_pkg::MODE_LOOKUP, 64'd9, 64'd16, 64'd0);
      send_request(pph_pkg::MODE_LOOKUP, '1, '1, 64'd0);
      send_request(pph_pkg::MODE_CLEAR, '1, '1, '1);
      send_request(pph_pkg::MODE_LOOKUP, 64'd0, 64'd0, 64'd0);
      send_request(pph_pkg::MODE_INSERT, 64'd5, '1, 64'd6);
   endtask

   task automatic test_fill_to_full();
      int e;
      send_request(pph_pkg::MODE_CLEAR, 64'd0, 64'd0, 64'd0);
      while (live_entries < ENTRY_CAP) begin
         send_request(pph_pkg::MODE_INSERT, rand64(), pick_hash(), rand64());
         if ($urandom_range(0, 9) == 0) begin
            e = $urandom_range(0, live_entries - 1);
            send_request(pph_pkg::MODE_LOOKUP, shadow_keys[e], shadow_hashes[e], 64'd0);
         end
      end
      repeat (3) send_request(pph_pkg::MODE_INSERT, rand64(), rand64(), rand64());
      e = $urandom_range(0, live_entries - 1);
      send_request(pph_pkg::MODE_INSERT, shadow_keys[e], shadow_hashes[e], rand64());
      drain_results();
      send_request(pph_pkg::MODE_CLEAR, 64'd0, 64'd0, 64'd0);
   endtask

   task automatic test_random_mix(int items);
      repeat (items) random_request();
   endtask

   always @(posedge clock) begin
      if (!reset && rsp_strobe) begin
         if (pending_q.size() == 0) begin
            mismatches++;
            if (mismatches <= 10)
               $display("unexpected result: status %0d value %h entry %0d",
                        rsp_status, rsp_found_value, rsp_entry_number);
         end else begin
            outcome_type want;
            want = pending_q.pop_front();
            if (rsp_status !== want.status || rsp_found_value !== want.found_value ||
                rsp_entry_number !== want.entry_number) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("mismatch: expected %0d/%h/%0d got %0d/%h/%0d",
                           want.status, want.found_value, want.entry_number,
                           rsp_status, rsp_found_value, rsp_entry_number);
            end
         end
      end
   end

   always @(posedge clock) begin
      took_item = start && !busy && !reset;
      if (reset || took_item || rsp_strobe) begin
         quiet_cycles <= 0;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
         if (quiet_cycles >= WATCH_LIMIT) begin
            $display("perturbed_probe_hash_table regression: fail");
            $finish;
         end
      end
   end

   initial begin
      mismatches = 0;
      quiet_cycles = 0;
      live_entries = 0;
      table_log2 = pph_pkg::MIN_SIZE_LOG2;
      wipe_slots();
      idle_pct = 10;
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      test_directed();
      test_fill_to_full();
      test_random_mix(300);
      idle_pct = 83;
      test_random_mix(450);
      idle_pct = 0;
      test_random_mix(450);
      drain_results();
      repeat (50) @(posedge clock);
      if (mismatches == 0 && pending_q.size() == 0)
         $display("perturbed_probe_hash_table regression: pass");
      else
         $display("perturbed_probe_hash_table regression: fail");
      $finish;
   end

endmodule
